@@ design/ope_pkg.sv @@
`default_nettype none

package ope_pkg;

  // opcodes
  localparam logic OP_LOAD     = 1'b0;
  localparam logic OP_ESTIMATE = 1'b1;

  // reset value of G: 1.0 in Q16.16
  localparam logic [31:0] GRAV_RESET = 32'h0001_0000;

  // floor(2*pi*2^28)
  localparam logic [30:0] TWO_PI_Q28 = 31'd1686629713;

  // mu is below 2^49, Q.16
  localparam int MU_W = 49;

  // sideband through the distance root and the first division
  typedef struct packed {
    logic            kill;
    logic [MU_W-1:0] mu;
    logic [MU_W-1:0] half_v2;
  } sb_energy_t;

  // sideband through the second division and the cube
  typedef struct packed {
    logic            kill;
    logic [MU_W-1:0] mu;
  } sb_axis_t;

  // sideband through the last division and root
  typedef struct packed {
    logic kill;
    logic sat;
  } sb_tail_t;

  // |a - b| of two signed 32-bit values, 33 bits unsigned
  function automatic logic [32:0] abs_diff(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] d;
    d = {a[31], a} - {b[31], b};
    return d[32] ? (~d + 33'd1) : d;
  endfunction

endpackage

`default_nettype wire

@@ design/ope_div.sv @@
`default_nettype none

// Restoring divider, one quotient bit per stage, NW stages.
// rem_i must be below den_i for a true quotient.
module ope_div #(
  parameter int NW  = 64,
  parameter int DW  = 32,
  parameter int SBW = 1
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  wire logic           valid_i,
  input  wire logic [NW-1:0]  num_i,
  input  wire logic [DW-1:0]  den_i,
  input  wire logic [DW-1:0]  rem_i,
  input  wire logic [SBW-1:0] sb_i,
  output logic                valid_o,
  output logic [NW-1:0]       quo_o,
  output logic [SBW-1:0]      sb_o
);

  logic           vld_q [NW];
  logic [NW-1:0]  num_q [NW];
  logic [DW-1:0]  rem_q [NW];
  logic [DW-1:0]  den_q [NW];
  logic [SBW-1:0] sb_q  [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic           vld_p;
    logic [NW-1:0]  num_p;
    logic [DW-1:0]  rem_p;
    logic [DW-1:0]  den_p;
    logic [SBW-1:0] sb_p;
    logic [DW:0]    rem_sh;
    logic [DW:0]    rem_sub;
    logic           ge;

    if (k == 0) begin : g_first
      assign vld_p = valid_i;
      assign num_p = num_i;
      assign rem_p = rem_i;
      assign den_p = den_i;
      assign sb_p  = sb_i;
    end else begin : g_next
      assign vld_p = vld_q[k-1];
      assign num_p = num_q[k-1];
      assign rem_p = rem_q[k-1];
      assign den_p = den_q[k-1];
      assign sb_p  = sb_q[k-1];
    end

    // bring down one numerator bit and trial-subtract
    always_comb begin
      rem_sh  = {rem_p, num_p[NW-1]};
      rem_sub = rem_sh - {1'b0, den_p};
      ge      = (rem_sh >= {1'b0, den_p});
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
        num_q[k] <= {num_p[NW-2:0], ge};
        den_q[k] <= den_p;
        sb_q[k]  <= sb_p;
      end
    end
  end

  assign valid_o = vld_q[NW-1];
  assign quo_o   = num_q[NW-1];
  assign sb_o    = sb_q[NW-1];

endmodule

`default_nettype wire

@@ design/ope_isqrt.sv @@
`default_nettype none

// Floor square root, two radicand bits per stage, IW/2 stages.
module ope_isqrt #(
  parameter int IW  = 64,
  parameter int SBW = 1
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  wire logic           valid_i,
  input  wire logic [IW-1:0]  x_i,
  input  wire logic [SBW-1:0] sb_i,
  output logic                valid_o,
  output logic [IW/2-1:0]     root_o,
  output logic [SBW-1:0]      sb_o
);

  localparam int RW = IW / 2;

  logic           vld_q  [RW];
  logic [IW-1:0]  x_q    [RW];
  logic [RW+1:0]  rem_q  [RW];
  logic [RW-1:0]  root_q [RW];
  logic [SBW-1:0] sb_q   [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic           vld_p;
    logic [IW-1:0]  x_p;
    logic [RW+1:0]  rem_p;
    logic [RW-1:0]  root_p;
    logic [SBW-1:0] sb_p;
    logic [RW+3:0]  rem_sh;
    logic [RW+3:0]  trial;
    logic [RW+3:0]  rem_sub;
    logic           ge;

    if (k == 0) begin : g_first
      assign vld_p  = valid_i;
      assign x_p    = x_i;
      assign rem_p  = '0;
      assign root_p = '0;
      assign sb_p   = sb_i;
    end else begin : g_next
      assign vld_p  = vld_q[k-1];
      assign x_p    = x_q[k-1];
      assign rem_p  = rem_q[k-1];
      assign root_p = root_q[k-1];
      assign sb_p   = sb_q[k-1];
    end

    // next two bits in, trial 4*root+1
    always_comb begin
      rem_sh  = {rem_p, x_p[IW-1:IW-2]};
      trial   = {2'b00, root_p, 2'b01};
      rem_sub = rem_sh - trial;
      ge      = (rem_sh >= trial);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? rem_sub[RW+1:0] : rem_sh[RW+1:0];
        root_q[k] <= {root_p[RW-2:0], ge};
        x_q[k]    <= {x_p[IW-3:0], 2'b00};
        sb_q[k]   <= sb_p;
      end
    end
  end

  assign valid_o = vld_q[RW-1];
  assign root_o  = root_q[RW-1];
  assign sb_o    = sb_q[RW-1];

endmodule

`default_nettype wire

@@ design/ope_cube.sv @@
`default_nettype none

// a^3 for a below 2^40, in four stages of 32-bit partial products.
// sat_o flags a >= 2^40.
module ope_cube (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              valid_i,
  input  wire logic [63:0]       a_i,
  input  wire ope_pkg::sb_axis_t sb_i,
  output logic                   valid_o,
  output logic [119:0]           a3_o,
  output logic                   sat_o,
  output ope_pkg::sb_axis_t      sb_o
);

  logic [3:0]        vld_q;
  logic              sat1_q, sat2_q, sat3_q, sat4_q;
  ope_pkg::sb_axis_t sb1_q, sb2_q, sb3_q, sb4_q;
  logic [31:0]       al1_q, al2_q;
  logic [7:0]        ah1_q, ah2_q;
  logic [63:0]       p_ll_q;
  logic [39:0]       p_lh_q;
  logic [15:0]       p_hh_q;
  logic [79:0]       a2_q;
  logic [63:0]       q00_q, q10_q;
  logic [47:0]       q20_q;
  logic [39:0]       q01_q, q11_q;
  logic [23:0]       q21_q;
  logic [119:0]      a3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // split a, square partials
      sat1_q <= (a_i[63:40] != 24'd0);
      sb1_q  <= sb_i;
      al1_q  <= a_i[31:0];
      ah1_q  <= a_i[39:32];
      p_ll_q <= 64'(a_i[31:0]) * 64'(a_i[31:0]);
      p_lh_q <= 40'(a_i[31:0]) * 40'(a_i[39:32]);
      p_hh_q <= 16'(a_i[39:32]) * 16'(a_i[39:32]);
      // a^2
      sat2_q <= sat1_q;
      sb2_q  <= sb1_q;
      al2_q  <= al1_q;
      ah2_q  <= ah1_q;
      a2_q   <= 80'(p_ll_q) + (80'(p_lh_q) << 33) + (80'(p_hh_q) << 64);
      // a^2 * a partials
      sat3_q <= sat2_q;
      sb3_q  <= sb2_q;
      q00_q  <= 64'(a2_q[31:0])  * 64'(al2_q);
      q10_q  <= 64'(a2_q[63:32]) * 64'(al2_q);
      q20_q  <= 48'(a2_q[79:64]) * 48'(al2_q);
      q01_q  <= 40'(a2_q[31:0])  * 40'(ah2_q);
      q11_q  <= 40'(a2_q[63:32]) * 40'(ah2_q);
      q21_q  <= 24'(a2_q[79:64]) * 24'(ah2_q);
      // a^3
      sat4_q <= sat3_q;
      sb4_q  <= sb3_q;
      a3_q   <= 120'(q00_q) + (120'(q10_q) << 32) + (120'(q20_q) << 64)
              + (120'(q01_q) << 32) + (120'(q11_q) << 64) + (120'(q21_q) << 96);
    end
  end

  assign valid_o = vld_q[3];
  assign a3_o    = a3_q;
  assign sat_o   = sat4_q;
  assign sb_o    = sb4_q;

endmodule

`default_nettype wire

@@ design/orbital_period_estimator.sv @@
`default_nettype none

// Channel  | Direction | Handshake                | Beat
// ---------+-----------+--------------------------+------------------------------------
// in       | input     | in_valid_i / in_ready_o  | opcode, position, velocity, mass, tag
// out      | output    | out_valid_o / out_ready_i| period, bound_orbit
// cfg      | input     | cfg_we_i (no wait)       | G, unsigned Q16.16
//
// One beat enters per cycle while no stall holds the pipe; an estimate passes
// the three 64-step dividers and two 32-step root units in the pipe.
// A load beat updates the primary at acceptance and leaves no result.
// Reset clears the primary valid flag and all stage valid bits and sets G to 1.0.
// A stalled output fills a skid register; the whole pipe then holds until
// the consumer takes a beat, losing nothing.
module orbital_period_estimator (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        opcode_i,
  input  wire logic [31:0] pos_x_i,
  input  wire logic [31:0] pos_y_i,
  input  wire logic [31:0] pos_z_i,
  input  wire logic [31:0] vel_x_i,
  input  wire logic [31:0] vel_y_i,
  input  wire logic [31:0] vel_z_i,
  input  wire logic [31:0] body_mass_i,
  input  wire logic [31:0] body_tag_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      period_o,
  output logic             bound_orbit_o
);

  localparam int MW = ope_pkg::MU_W;

  logic en;
  logic accept;

  // config and primary body
  logic [31:0] grav_q;
  logic [31:0] prim_pos_q [3];
  logic [31:0] prim_vel_q [3];
  logic [31:0] prim_mass_q;
  logic [31:0] prim_tag_q;
  logic        prim_valid_q;

  assign accept = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grav_q <= ope_pkg::GRAV_RESET;
    end else if (cfg_we_i) begin
      grav_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prim_valid_q <= 1'b0;
      prim_pos_q   <= '{default: '0};
      prim_vel_q   <= '{default: '0};
      prim_mass_q  <= '0;
      prim_tag_q   <= '0;
    end else if (accept && opcode_i == ope_pkg::OP_LOAD) begin
      prim_valid_q  <= 1'b1;
      prim_pos_q[0] <= pos_x_i;
      prim_pos_q[1] <= pos_y_i;
      prim_pos_q[2] <= pos_z_i;
      prim_vel_q[0] <= vel_x_i;
      prim_vel_q[1] <= vel_y_i;
      prim_vel_q[2] <= vel_z_i;
      prim_mass_q   <= body_mass_i;
      prim_tag_q    <= body_tag_i;
    end
  end

  // stage 1: relative deltas, total mass, early rejects
  logic        v1_q, kill1_q;
  logic [32:0] u1_q [6];
  logic [32:0] mtot1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= accept && opcode_i == ope_pkg::OP_ESTIMATE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      u1_q[0] <= ope_pkg::abs_diff(pos_x_i, prim_pos_q[0]);
      u1_q[1] <= ope_pkg::abs_diff(pos_y_i, prim_pos_q[1]);
      u1_q[2] <= ope_pkg::abs_diff(pos_z_i, prim_pos_q[2]);
      u1_q[3] <= ope_pkg::abs_diff(vel_x_i, prim_vel_q[0]);
      u1_q[4] <= ope_pkg::abs_diff(vel_y_i, prim_vel_q[1]);
      u1_q[5] <= ope_pkg::abs_diff(vel_z_i, prim_vel_q[2]);
      mtot1_q <= {1'b0, prim_mass_q} + {1'b0, body_mass_i};
      kill1_q <= !prim_valid_q || (body_tag_i == prim_tag_q);
    end
  end

  // stage 2: quartered squares, mu = G*(m1+m2)
  logic          v2_q, kill2_q;
  logic [63:0]   sq2_q [6];
  logic [MW-1:0] mu2_q;
  logic [65:0]   sq_full [6];
  logic [64:0]   gm_full;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      sq_full[i] = 66'(u1_q[i]) * 66'(u1_q[i]);
    end
    gm_full = 65'(grav_q) * 65'(mtot1_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 6; i++) begin
        sq2_q[i] <= sq_full[i][65:2];
      end
      mu2_q   <= gm_full[64:16];
      kill2_q <= kill1_q;
    end
  end

  // stage 3: r^2, v^2/2
  logic                   v3_q;
  logic [63:0]            r2_q;
  ope_pkg::sb_energy_t    sb3_q;
  logic [63:0]            r2_sum, v2_sum;

  always_comb begin
    r2_sum = sq2_q[0] + sq2_q[1] + sq2_q[2];
    v2_sum = sq2_q[3] + sq2_q[4] + sq2_q[5];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= v2_q;
    end
  end

  // r is zero exactly when r^2 is zero
  always_ff @(posedge clk_i) begin
    if (en) begin
      r2_q          <= r2_sum;
      sb3_q.kill    <= kill2_q || (r2_sum == 64'd0) || (mu2_q == '0);
      sb3_q.mu      <= mu2_q;
      sb3_q.half_v2 <= v2_sum[63:15];
    end
  end

  // distance root
  logic                vr;
  logic [31:0]         r_root;
  ope_pkg::sb_energy_t sbr;

  ope_isqrt #(
    .IW  (64),
    .SBW ($bits(ope_pkg::sb_energy_t))
  ) u_isqrt_r (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v3_q),
    .x_i     (r2_q),
    .sb_i    (sb3_q),
    .valid_o (vr),
    .root_o  (r_root),
    .sb_o    (sbr)
  );

  // mu/r
  logic                vmr;
  logic [63:0]         mu_over_r;
  ope_pkg::sb_energy_t sbmr;

  ope_div #(
    .NW  (64),
    .DW  (32),
    .SBW ($bits(ope_pkg::sb_energy_t))
  ) u_div_mr (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vr),
    .num_i   ({sbr.mu, 15'd0}),
    .den_i   (r_root),
    .rem_i   (32'd0),
    .sb_i    (sbr),
    .valid_o (vmr),
    .quo_o   (mu_over_r),
    .sb_o    (sbmr)
  );

  // stage 4: -E, reject unbound orbits
  logic              v4_q;
  logic [63:0]       neg_e4_q;
  ope_pkg::sb_axis_t sb4_q;
  logic [63:0]       hv2_ext;

  assign hv2_ext = 64'(sbmr.half_v2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en) begin
      v4_q <= vmr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      neg_e4_q   <= mu_over_r - hv2_ext;
      sb4_q.kill <= sbmr.kill || (hv2_ext >= mu_over_r);
      sb4_q.mu   <= sbmr.mu;
    end
  end

  // semi-major axis a = mu/(-2E)
  logic              va;
  logic [63:0]       axis_a;
  ope_pkg::sb_axis_t sba;

  ope_div #(
    .NW  (64),
    .DW  (64),
    .SBW ($bits(ope_pkg::sb_axis_t))
  ) u_div_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v4_q),
    .num_i   ({sb4_q.mu, 15'd0}),
    .den_i   (neg_e4_q),
    .rem_i   (64'd0),
    .sb_i    (sb4_q),
    .valid_o (va),
    .quo_o   (axis_a),
    .sb_o    (sba)
  );

  // a^3
  logic              vc;
  logic [119:0]      a3;
  logic              sat_a;
  ope_pkg::sb_axis_t sbc;

  ope_cube u_cube (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (va),
    .a_i     (axis_a),
    .sb_i    (sba),
    .valid_o (vc),
    .a3_o    (a3),
    .sat_o   (sat_a),
    .sb_o    (sbc)
  );

  // a^3/mu; quotient overflows 64 bits when the upper half reaches mu
  ope_pkg::sb_tail_t sbq_in;
  logic              vq;
  logic [63:0]       quo_x;
  ope_pkg::sb_tail_t sbq;

  always_comb begin
    sbq_in.kill = sbc.kill;
    sbq_in.sat  = sat_a || (a3[119:64] >= 56'(sbc.mu));
  end

  ope_div #(
    .NW  (64),
    .DW  (MW),
    .SBW ($bits(ope_pkg::sb_tail_t))
  ) u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vc),
    .num_i   (a3[63:0]),
    .den_i   (sbc.mu),
    .rem_i   (a3[64+MW-1:64]),
    .sb_i    (sbq_in),
    .valid_o (vq),
    .quo_o   (quo_x),
    .sb_o    (sbq)
  );

  // sqrt(a^3/mu)
  logic              vs;
  logic [31:0]       s_root;
  ope_pkg::sb_tail_t sbs;

  ope_isqrt #(
    .IW  (64),
    .SBW ($bits(ope_pkg::sb_tail_t))
  ) u_isqrt_s (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vq),
    .x_i     (quo_x),
    .sb_i    (sbq),
    .valid_o (vs),
    .root_o  (s_root),
    .sb_o    (sbs)
  );

  // stage 5: times 2*pi
  logic              v5_q;
  logic [62:0]       prod5_q;
  ope_pkg::sb_tail_t sb5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (en) begin
      v5_q <= vs;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod5_q <= 63'(s_root) * 63'(ope_pkg::TWO_PI_Q28);
      sb5_q   <= sbs;
    end
  end

  // final result with saturation and forced zero
  logic [31:0] fin_period;
  logic        fin_bound;
  logic [34:0] t_full;

  always_comb begin
    t_full    = prod5_q[62:28];
    fin_bound = !sb5_q.kill;
    if (sb5_q.kill) begin
      fin_period = 32'd0;
    end else if (sb5_q.sat || t_full[34:32] != 3'd0) begin
      fin_period = 32'hFFFF_FFFF;
    end else begin
      fin_period = t_full[31:0];
    end
  end

  // output register with skid
  logic        out_v_q, skid_v_q;
  logic [31:0] out_period_q, skid_period_q;
  logic        out_bound_q, skid_bound_q;
  logic        push;

  assign en         = !skid_v_q;
  assign in_ready_o = en;
  assign push       = v5_q && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!out_v_q || out_ready_i) begin
      out_v_q  <= skid_v_q || push;
      skid_v_q <= 1'b0;
    end else if (push) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || out_ready_i) begin
      out_period_q <= skid_v_q ? skid_period_q : fin_period;
      out_bound_q  <= skid_v_q ? skid_bound_q : fin_bound;
    end else if (push) begin
      skid_period_q <= fin_period;
      skid_bound_q  <= fin_bound;
    end
  end

  assign out_valid_o   = out_v_q;
  assign period_o      = out_period_q;
  assign bound_orbit_o = out_bound_q;

endmodule

`default_nettype wire

@@ design/ope_checker.sv @@
`default_nettype none

module ope_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [31:0] period_o,
  input wire logic        bound_orbit_o
);

  // a waiting result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(period_o) && $stable(bound_orbit_o))
    else $error("result beat dropped or changed while stalled");

  // unbound results carry a zero period
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !bound_orbit_o |-> period_o == 32'd0)
    else $error("unbound result with nonzero period");

  // input only back-pressured after an output stall
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> $past(out_valid_o && !out_ready_i))
    else $error("input stalled without output stall");

  // stall clears in the cycle after the consumer takes a beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o && out_ready_i |=> in_ready_o)
    else $error("input stall held after output drained");

endmodule

bind orbital_period_estimator ope_checker u_ope_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .period_o      (period_o),
  .bound_orbit_o (bound_orbit_o)
);

`default_nettype wire
